FILE: rtl/bba_pkg.sv
// Shared types, codes and constants of the buddy block allocator.
package bba_pkg;

  localparam int DEF_MAX_DEPTH      = 10;
  localparam int DEF_MIN_BLOCK_LOG2 = 5;

  localparam int CFG_W     = 4;
  localparam int SIZE_W    = 16;
  localparam int OFFSET_W  = 16;
  localparam int BLK_OFS_W = 15;
  localparam int USED_W    = 16;
  localparam int STATUS_W  = 3;

  localparam logic [CFG_W-1:0] DEPTH_RST = 4'd10;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef logic [1:0] node_st_t;
  localparam node_st_t NODE_FREE  = 2'd0;
  localparam node_st_t NODE_ALLOC = 2'd1;
  localparam node_st_t NODE_SPLIT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_MEM    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_FIT    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 3'd5;

  typedef struct packed {
    logic                cmd;
    logic [SIZE_W-1:0]   req_size;
    logic [OFFSET_W-1:0] free_offset;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [BLK_OFS_W-1:0] block_offset;
    logic [USED_W-1:0]    used_bytes;
  } result_t;

endpackage

FILE: rtl/bba_if.sv
// Channel interfaces: command input, result output and depth register write.
interface bba_req_if;
  import bba_pkg::*;
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [SIZE_W-1:0]   req_size;
  logic [OFFSET_W-1:0] free_offset;
  modport source (output valid, cmd, req_size, free_offset, input ready);
  modport sink   (input valid, cmd, req_size, free_offset, output ready);
endinterface

interface bba_rsp_if;
  import bba_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [BLK_OFS_W-1:0] block_offset;
  logic [USED_W-1:0]    used_bytes;
  modport source (output valid, status, block_offset, used_bytes, input ready);
  modport sink   (input valid, status, block_offset, used_bytes, output ready);
endinterface

interface bba_cfg_if;
  import bba_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] tree_depth;
  modport source (output valid, tree_depth, input ready);
  modport sink   (input valid, tree_depth, output ready);
endinterface

FILE: rtl/buddy_block_allocator_unit.sv
// A command whose size or offset checks fail goes straight to the result; a request otherwise walks
// the tree with node reads, backtrack steps and split or grant writes; a free probes levels,
// reads the candidate at each aligned level, ends if no level holds the block, then merges
// upward. Throughput: one command at a time; the next transfer is taken once the result leaves
// the sequencer, while the result register holds it.
// Reset (sync, rst high): count cleared, tree_depth 10, every node cleared to free.
module buddy_block_allocator_unit #(
  parameter int MAX_DEPTH      = bba_pkg::DEF_MAX_DEPTH,
  parameter int MIN_BLOCK_LOG2 = bba_pkg::DEF_MIN_BLOCK_LOG2
) (
  input logic       clk,
  input logic       rst,
  bba_req_if.sink   req,
  bba_rsp_if.source rsp,
  bba_cfg_if.sink   cfg
);
  import bba_pkg::*;

  localparam int LVL_W = $clog2(MAX_DEPTH + 2);

  logic [CFG_W-1:0] tree_depth;
  logic [LVL_W-1:0] depth;
  item_t            item;
  result_t          res;
  logic             res_valid;
  logic             res_ready;
  logic             rsp_valid;
  result_t          rsp_data;

  // Depth register: always writable; the user writes it only while idle, unenforced by the block.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tree_depth <= DEPTH_RST;
    end else if (cfg.valid) begin
      tree_depth <= cfg.tree_depth;
    end
  end

  // depths beyond the tree built at elaboration act as the deepest one
  assign depth = (tree_depth > CFG_W'(MAX_DEPTH)) ? LVL_W'(MAX_DEPTH) : LVL_W'(tree_depth);

  assign item.cmd         = req.cmd;
  assign item.req_size    = req.req_size;
  assign item.free_offset = req.free_offset;

  bba_seq #(
    .MAX_DEPTH      (MAX_DEPTH),
    .MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2),
    .LVL_W          (LVL_W)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .depth      (depth),
    .item_valid (req.valid),
    .item_ready (req.ready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // Output register: loads a finished result when empty or being drained.
  assign res_ready = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp_data <= res;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_data.status;
  assign rsp.block_offset = rsp_data.block_offset;
  assign rsp.used_bytes   = rsp_data.used_bytes;

endmodule

FILE: rtl/bba_node_ram.sv
// Node state memory: one write port, one registered read port.
module bba_node_ram #(
  parameter int ADDR_W = 11,
  parameter int DEPTH  = 2047
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  bba_pkg::node_st_t wdata,
  input  logic [ADDR_W-1:0] raddr,
  output bba_pkg::node_st_t rdata
);
  import bba_pkg::*;

  node_st_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-during-write to the same address returns the old value
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/bba_seq.sv
// Allocator sequencer: size checks, tree walk, split, free search and merge.
module bba_seq #(
  parameter int MAX_DEPTH      = bba_pkg::DEF_MAX_DEPTH,
  parameter int MIN_BLOCK_LOG2 = bba_pkg::DEF_MIN_BLOCK_LOG2,
  parameter int LVL_W          = $clog2(MAX_DEPTH + 2)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [LVL_W-1:0] depth,
  input  logic             item_valid,
  output logic             item_ready,
  input  bba_pkg::item_t   item,
  output logic             res_valid,
  input  logic             res_ready,
  output bba_pkg::result_t res
);
  import bba_pkg::*;

  localparam int NODE_W     = MAX_DEPTH + 1;
  localparam int NODE_COUNT = (1 << (MAX_DEPTH + 1)) - 1;
  localparam int POOL_W     = MIN_BLOCK_LOG2 + MAX_DEPTH + 1;
  localparam int CMP_W      = ((POOL_W > SIZE_W) ? POOL_W : SIZE_W) + 2;
  localparam int SH_W       = $clog2(MIN_BLOCK_LOG2 + MAX_DEPTH + 1);
  localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(NODE_COUNT - 1);
  localparam logic [5:0]        MBL6      = 6'(MIN_BLOCK_LOG2);

  typedef enum logic [11:0] {
    S_CLEAR = 12'b0000_0000_0001,
    S_IDLE  = 12'b0000_0000_0010,
    S_CHECK = 12'b0000_0000_0100,
    S_RD    = 12'b0000_0000_1000,
    S_EVAL  = 12'b0000_0001_0000,
    S_BACK  = 12'b0000_0010_0000,
    S_SPLIT = 12'b0000_0100_0000,
    S_FRD   = 12'b0000_1000_0000,
    S_FEVAL = 12'b0001_0000_0000,
    S_MRD   = 12'b0010_0000_0000,
    S_MEVAL = 12'b0100_0000_0000,
    S_DONE  = 12'b1000_0000_0000
  } state_t;

  // bit length of v, i.e. ceil(log2(v + 1))
  function automatic logic [4:0] bit_len(input logic [SIZE_W-1:0] v);
    logic [4:0] r;
    r = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (v[i]) r = 5'(i + 1);
    end
    return r;
  endfunction

  state_t state, state_next;

  logic                  cmd_r;
  logic [SIZE_W-1:0]     size_r;
  logic [OFFSET_W-1:0]   off_r;
  logic [NODE_W-1:0]     idx;
  logic [LVL_W-1:0]      lvl;
  logic [LVL_W-1:0]      target;
  logic [USED_W-1:0]     used_total;
  logic [STATUS_W-1:0]   res_status;
  logic [BLK_OFS_W-1:0]  res_offset;

  node_st_t              rd_st;
  logic                  mem_we;
  logic [NODE_W-1:0]     mem_waddr;
  node_st_t              mem_wdata;
  logic [NODE_W-1:0]     mem_raddr;

  // shared datapath terms
  logic [SH_W-1:0]       pool_log2;
  logic [SH_W-1:0]       blog;
  logic [CMP_W-1:0]      pool;
  logic [CMP_W-1:0]      bsize;
  logic [CMP_W-1:0]      size_ext;
  logic [CMP_W-1:0]      used_ext;
  logic [CMP_W-1:0]      off_ext;
  logic [SIZE_W-1:0]     size1;
  logic [5:0]            size_len;
  logic [LVL_W-1:0]      tgt_calc;
  logic                  too_large;
  logic                  no_mem;
  logic                  off_out;
  logic                  aligned;
  logic [NODE_W-1:0]     cand;
  logic [NODE_W-1:0]     left;
  logic [NODE_W-1:0]     parent;
  logic [NODE_W-1:0]     buddy;
  logic [NODE_W-1:0]     pos;
  logic [CMP_W-1:0]      grant_off;

  always_comb begin
    pool_log2 = SH_W'(MIN_BLOCK_LOG2) + SH_W'(depth);
    blog      = pool_log2 - SH_W'(lvl);
    pool      = CMP_W'(1) << pool_log2;
    bsize     = CMP_W'(1) << blog;
    size1     = (size_r == '0) ? SIZE_W'(1) : size_r;
    size_ext  = CMP_W'(size1);
    used_ext  = CMP_W'(used_total);
    off_ext   = CMP_W'(off_r);
    too_large = size_ext > pool;
    // a pool smaller than the running count never reports short of memory
    no_mem    = (used_ext <= pool) && ((size_ext + used_ext) > pool);
    off_out   = off_ext > (pool - (CMP_W'(1) << MIN_BLOCK_LOG2));
    size_len  = {1'b0, bit_len(size1 - SIZE_W'(1))};
    tgt_calc  = (size_len > MBL6) ? depth - LVL_W'(size_len - MBL6) : depth;
    aligned   = (off_ext & (bsize - CMP_W'(1))) == '0;
    cand      = ((NODE_W'(1) << lvl) - NODE_W'(1)) + NODE_W'(off_ext >> blog);
    left      = {idx[NODE_W-2:0], 1'b1};
    parent    = (idx - NODE_W'(1)) >> 1;
    buddy     = idx[0] ? idx + NODE_W'(1) : idx - NODE_W'(1);
    pos       = idx + NODE_W'(1) - (NODE_W'(1) << lvl);
    grant_off = CMP_W'(pos) << blog;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (idx == NODE_LAST) state_next = S_IDLE;
      S_IDLE:  if (item_valid) state_next = S_CHECK;
      S_CHECK: begin
        if (cmd_r == CMD_ALLOC) begin
          state_next = (too_large || no_mem) ? S_DONE : S_RD;
        end else begin
          state_next = off_out ? S_DONE : S_FRD;
        end
      end
      S_RD:    state_next = S_EVAL;
      S_EVAL: begin
        if (rd_st == NODE_FREE) begin
          state_next = S_SPLIT;
        end else if (rd_st == NODE_SPLIT && lvl < target) begin
          state_next = S_RD;
        end else begin
          state_next = S_BACK;
        end
      end
      S_BACK: begin
        if (idx == '0) begin
          state_next = S_DONE;
        end else if (idx[0]) begin
          state_next = S_RD;
        end
      end
      S_SPLIT: if (lvl >= target) state_next = S_DONE;
      S_FRD: begin
        if (lvl > depth) begin
          state_next = S_DONE;
        end else if (aligned) begin
          state_next = S_FEVAL;
        end
      end
      S_FEVAL: state_next = (rd_st == NODE_ALLOC) ? S_MRD : S_FRD;
      S_MRD:   state_next = (idx == '0) ? S_DONE : S_MEVAL;
      S_MEVAL: state_next = (rd_st == NODE_FREE) ? S_MRD : S_DONE;
      S_DONE:  if (res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = NODE_FREE;
    mem_raddr = idx;
    case (state)
      S_CLEAR: mem_we = 1'b1;
      S_SPLIT: begin
        mem_we    = 1'b1;
        mem_wdata = (lvl < target) ? NODE_SPLIT : NODE_ALLOC;
      end
      S_FRD:   mem_raddr = cand;
      S_FEVAL: mem_we = (rd_st == NODE_ALLOC);
      S_MRD:   mem_raddr = buddy;
      S_MEVAL: begin
        mem_we    = (rd_st == NODE_FREE);
        mem_waddr = parent;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      idx        <= '0;
      lvl        <= '0;
      used_total <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_CLEAR: idx <= idx + NODE_W'(1);
        S_IDLE: begin
          if (item_valid) begin
            cmd_r      <= item.cmd;
            size_r     <= item.req_size;
            off_r      <= item.free_offset;
            idx        <= '0;
            lvl        <= '0;
            res_status <= ST_OK;
            res_offset <= '0;
          end
        end
        S_CHECK: begin
          target <= tgt_calc;
          if (cmd_r == CMD_ALLOC) begin
            if (too_large) begin
              res_status <= ST_TOO_LARGE;
            end else if (no_mem) begin
              res_status <= ST_NO_MEM;
            end
          end else if (off_out) begin
            res_status <= ST_OUTSIDE;
          end
        end
        S_EVAL: begin
          if (rd_st == NODE_SPLIT && lvl < target) begin
            idx <= left;
            lvl <= lvl + LVL_W'(1);
          end
        end
        S_BACK: begin
          if (idx == '0) begin
            res_status <= ST_NO_FIT;
          end else if (idx[0]) begin
            idx <= idx + NODE_W'(1);
          end else begin
            idx <= parent;
            lvl <= lvl - LVL_W'(1);
          end
        end
        S_SPLIT: begin
          if (lvl < target) begin
            idx <= left;
            lvl <= lvl + LVL_W'(1);
          end else begin
            res_offset <= grant_off[BLK_OFS_W-1:0];
            used_total <= used_total + bsize[USED_W-1:0];
          end
        end
        S_FRD: begin
          if (lvl > depth) begin
            res_status <= ST_NOT_ALLOC;
          end else if (aligned) begin
            idx <= cand;
          end else begin
            lvl <= lvl + LVL_W'(1);
          end
        end
        S_FEVAL: begin
          if (rd_st == NODE_ALLOC) begin
            used_total <= used_total - bsize[USED_W-1:0];
          end else begin
            lvl <= lvl + LVL_W'(1);
          end
        end
        S_MEVAL: if (rd_st == NODE_FREE) idx <= parent;
        default: ;
      endcase
    end
  end

  assign item_ready       = (state == S_IDLE);
  assign res_valid        = (state == S_DONE);
  assign res.status       = res_status;
  assign res.block_offset = res_offset;
  assign res.used_bytes   = used_total;

  bba_node_ram #(
    .ADDR_W (NODE_W),
    .DEPTH  (NODE_COUNT)
  ) u_node_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_st)
  );

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the buddy block allocator: directed table, then random phases.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  // Block geometry at the default parameters of the unit.
  localparam int MAX_D    = DEF_MAX_DEPTH;
  localparam int MIN_LOG2 = DEF_MIN_BLOCK_LOG2;
  localparam int NODES    = (1 << (MAX_D + 1)) - 1;
  localparam int PHASE_ITEMS = 160;

  logic clk;
  logic rst;

  bba_req_if req_ch ();
  bba_rsp_if rsp_ch ();
  bba_cfg_if cfg_ch ();

  buddy_block_allocator_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // One row of the directed table. When known is set, the typed result is what
  // the check uses; otherwise the predicted one is.
  typedef struct packed {
    logic                 cmd;
    logic [SIZE_W-1:0]    size;
    logic [OFFSET_W-1:0]  ofs;
    logic                 known;
    logic [STATUS_W-1:0]  st;
    logic [BLK_OFS_W-1:0] bofs;
    logic [USED_W-1:0]    used;
  } dir_row_t;

  // Depth 10 after reset, pool of 32768 bytes in 32-byte minimum blocks.
  dir_row_t steps [22] = '{
    '{CMD_ALLOC, 16'd0,      16'd0,      1'b1, ST_OK,        15'd0, 16'd32},    // size 0 -> 1
    '{CMD_ALLOC, 16'hFFFF,   16'd0,      1'b1, ST_TOO_LARGE, 15'd0, 16'd32},
    '{CMD_ALLOC, 16'd32768,  16'd0,      1'b1, ST_NO_MEM,    15'd0, 16'd32},
    '{CMD_FREE,  16'd0,      16'hFFFF,   1'b1, ST_OUTSIDE,   15'd0, 16'd32},
    '{CMD_FREE,  16'd0,      16'd32736,  1'b1, ST_NOT_ALLOC, 15'd0, 16'd32},    // last block
    '{CMD_FREE,  16'd0,      16'd0,      1'b1, ST_OK,        15'd0, 16'd0},     // merge to root
    '{CMD_ALLOC, 16'd32768,  16'd0,      1'b1, ST_OK,        15'd0, 16'd32768}, // whole pool
    '{CMD_ALLOC, 16'd1,      16'd0,      1'b1, ST_NO_MEM,    15'd0, 16'd32768},
    '{CMD_FREE,  16'd0,      16'd0,      1'b1, ST_OK,        15'd0, 16'd0},     // root, no merge
    '{CMD_ALLOC, 16'd8192,   16'd0,      1'b0, ST_OK,        15'd0, 16'd0},
    '{CMD_ALLOC, 16'd8192,   16'd0,      1'b0, ST_OK,        15'd0, 16'd0},
    '{CMD_ALLOC, 16'd8192,   16'd0,      1'b0, ST_OK,        15'd0, 16'd0},
    '{CMD_FREE,  16'd0,      16'd8192,   1'b0, ST_OK,        15'd0, 16'd0},
    // enough bytes free but fragmented: split node at target level, search exhausted
    '{CMD_ALLOC, 16'd16384,  16'd0,      1'b1, ST_NO_FIT,    15'd0, 16'd16384},
    '{CMD_ALLOC, 16'd16385,  16'd0,      1'b0, ST_OK,        15'd0, 16'd0},
    '{CMD_FREE,  16'd0,      16'd0,      1'b0, ST_OK,        15'd0, 16'd0},
    '{CMD_FREE,  16'd0,      16'd16384,  1'b0, ST_OK,        15'd0, 16'd0},
    '{CMD_ALLOC, 16'd32767,  16'd0,      1'b0, ST_OK,        15'd0, 16'd0},
    '{CMD_FREE,  16'hAAAA,   16'h5555,   1'b0, ST_OK,        15'd0, 16'd0},
    '{CMD_FREE,  16'd0,      16'd0,      1'b0, ST_OK,        15'd0, 16'd0},
    '{CMD_ALLOC, 16'hAAAA,   16'h5555,   1'b0, ST_OK,        15'd0, 16'd0},
    '{CMD_FREE,  16'd0,      16'h7FFF,   1'b0, ST_OK,        15'd0, 16'd0}
  };

  // Predictor state: node tree, byte count, depth register.
  node_st_t         tree_nodes [NODES];
  logic [USED_W-1:0] held_bytes;
  logic [CFG_W-1:0]  depth_reg;

  result_t          due_results [$];   // expected results, oldest first
  logic [OFFSET_W-1:0] live_offsets [$]; // granted blocks, used to build legal frees
  int               errors;
  int               burst_left;

  // Clock: 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Time limit, far above the slowest legal run (full-tree searches on every item).
  initial begin
    #400ms;
    $display("Verification failed");
    $finish;
  end

  // Next allocator state and result for one accepted command.
  function automatic result_t pool_apply(item_t it);
    int unsigned     d, plog, tgt, lvl, idx, blog, cand, buddy;
    longint unsigned pool, sz, off, bsize;
    bit              hit, done;
    result_t         r;
    d    = (depth_reg > MAX_D) ? MAX_D : depth_reg;
    plog = MIN_LOG2 + d;
    pool = 64'd1 << plog;
    r    = '0;
    hit  = 1'b0;
    done = 1'b0;
    idx  = 0;
    lvl  = 0;
    if (it.cmd == CMD_ALLOC) begin
      sz = (it.req_size == '0) ? 64'd1 : 64'(it.req_size);
      if (sz > pool) begin
        r.status = ST_TOO_LARGE;
      end else if (sz > pool - 64'(held_bytes)) begin
        // count above the pool wraps the difference, so the check passes
        r.status = ST_NO_MEM;
      end else begin
        tgt = 0;
        while (tgt < d && sz <= (pool >> (tgt + 1))) tgt++;
        // depth-first, left first; split nodes above target are entered
        while (!done) begin
          if (tree_nodes[idx] == NODE_FREE) begin
            while (lvl < tgt) begin
              tree_nodes[idx] = NODE_SPLIT;
              idx = 2 * idx + 1;
              lvl++;
            end
            tree_nodes[idx] = NODE_ALLOC;
            hit  = 1'b1;
            done = 1'b1;
          end else if (tree_nodes[idx] == NODE_SPLIT && lvl < tgt) begin
            idx = 2 * idx + 1;
            lvl++;
          end else begin
            while (idx != 0 && idx % 2 == 0) begin
              idx = (idx - 1) / 2;
              lvl--;
            end
            if (idx == 0) done = 1'b1;
            else idx = idx + 1;
          end
        end
        if (!hit) begin
          r.status = ST_NO_FIT;
        end else begin
          blog = plog - tgt;
          r.block_offset = BLK_OFS_W'((idx - ((1 << tgt) - 1)) << blog);
          held_bytes = held_bytes + USED_W'(64'd1 << blog);
        end
      end
    end else begin
      off = 64'(it.free_offset);
      if (off > pool - (64'd1 << MIN_LOG2)) begin
        r.status = ST_OUTSIDE;
      end else begin
        for (lvl = 0; lvl <= d && !hit; lvl++) begin
          blog  = plog - lvl;
          bsize = 64'd1 << blog;
          if ((off & (bsize - 1)) == 0) begin
            cand = (1 << lvl) - 1 + 32'(off >> blog);
            if (cand < NODES && tree_nodes[cand] == NODE_ALLOC) begin
              hit = 1'b1;
              idx = cand;
              tree_nodes[cand] = NODE_FREE;
              held_bytes = held_bytes - USED_W'(bsize);
            end
          end
        end
        if (!hit) begin
          r.status = ST_NOT_ALLOC;
        end else begin
          // merge upward while the buddy is free
          while (idx > 0 && !done) begin
            buddy = (idx % 2 == 1) ? idx + 1 : idx - 1;
            if (tree_nodes[buddy] != NODE_FREE) begin
              done = 1'b1;
            end else begin
              idx = (idx - 1) / 2;
              tree_nodes[idx] = NODE_FREE;
            end
          end
        end
      end
    end
    r.used_bytes = held_bytes;
    return r;
  endfunction

  // Drive one command, wait for its transfer, record the expectation, then
  // apply the sender's burst/gap pacing. Called and returns at a falling edge.
  task automatic send_cmd(item_t it, bit known, result_t want);
    result_t pred;
    int      gap;
    req_ch.valid       <= 1'b1;
    req_ch.cmd         <= it.cmd;
    req_ch.req_size    <= it.req_size;
    req_ch.free_offset <= it.free_offset;
    do @(posedge clk); while (!req_ch.ready);
    pred = pool_apply(it);
    due_results.push_back(known ? want : pred);
    if (it.cmd == CMD_ALLOC && pred.status == ST_OK)
      live_offsets.push_back(OFFSET_W'(pred.block_offset));
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // long bursts now and then give stretches with no gaps at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = $urandom_range(0, 7);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Let every outstanding result drain, then give the unit time to settle.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Register write, only issued with the unit idle.
  task automatic write_depth(logic [CFG_W-1:0] d);
    drain();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.tree_depth <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    depth_reg = d;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Result side: ready follows a stall pattern that switches between modes
  // (always ready, periodic, coin flip, long stalls).
  initial begin
    int mode, left, cnt, period, hold;
    rsp_ch.ready = 1'b0;
    left = 0;
    cnt  = 0;
    hold = 0;
    mode = 0;
    period = 2;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode   = $urandom_range(0, 3);
        left   = $urandom_range(64, 512);
        period = $urandom_range(2, 5);
      end
      left--;
      cnt++;
      case (mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= (cnt % period != 0);
        2: rsp_ch.ready <= 1'($urandom_range(0, 1));
        default: begin
          if (hold > 0) begin
            hold--;
            rsp_ch.ready <= 1'b0;
          end else begin
            if ($urandom_range(0, 7) == 0) hold = $urandom_range(1, 12);
            rsp_ch.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Result check: each transfer against the oldest expectation, field by field.
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d offset=%0d used=%0d", $time,
                 rsp_ch.status, rsp_ch.block_offset, rsp_ch.used_bytes);
        errors++;
      end else begin
        exp_r = due_results.pop_front();
        if (rsp_ch.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, rsp_ch.status);
          errors++;
        end
        if (rsp_ch.block_offset !== exp_r.block_offset) begin
          $display("%0t: block_offset expected %0d actual %0d", $time,
                   exp_r.block_offset, rsp_ch.block_offset);
          errors++;
        end
        if (rsp_ch.used_bytes !== exp_r.used_bytes) begin
          $display("%0t: used_bytes expected %0d actual %0d", $time,
                   exp_r.used_bytes, rsp_ch.used_bytes);
          errors++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, then random phases over several depths.
  initial begin
    item_t          it;
    result_t        none;
    int             d, plog, k, pick, i, ph, n;
    logic [CFG_W-1:0] depths [10];
    depths = '{4'd10, 4'd0, 4'd1, 4'd15, 4'd4, 4'd11, 4'd7, 4'd2, 4'd10, 4'd3};
    none   = '0;
    errors = 0;
    burst_left = 0;
    held_bytes = '0;
    depth_reg  = DEPTH_RST;
    foreach (tree_nodes[j]) tree_nodes[j] = NODE_FREE;

    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.cmd         = CMD_ALLOC;
    req_ch.req_size    = '0;
    req_ch.free_offset = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.tree_depth  = DEPTH_RST;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // the unit clears its node store after reset; ready stays low meanwhile,
    // so the first transfer simply waits for it

    foreach (steps[s]) begin
      it.cmd         = steps[s].cmd;
      it.req_size    = steps[s].size;
      it.free_offset = steps[s].ofs;
      send_cmd(it, steps[s].known,
               '{status: steps[s].st, block_offset: steps[s].bofs,
                 used_bytes: steps[s].used});
    end

    for (ph = 0; ph < 10; ph++) begin
      // depth may change with blocks held; the tree is read as it stands
      write_depth(depths[ph]);
      d    = (depths[ph] > MAX_D) ? MAX_D : depths[ph];
      plog = MIN_LOG2 + d;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        it.req_size    = SIZE_W'($urandom);
        it.free_offset = OFFSET_W'($urandom);
        // more frees when many blocks are held, so the tree keeps churning
        pick = $urandom_range(0, 99);
        if (pick < ((live_offsets.size() > 10) ? 55 : 30)) begin
          it.cmd = CMD_FREE;
          k = $urandom_range(0, 99);
          if (live_offsets.size() != 0 && k < 75) begin
            i = $urandom_range(0, live_offsets.size() - 1);
            it.free_offset = live_offsets[i];
            live_offsets.delete(i);
          end else if (k < 90) begin
            // aligned to a minimum block, inside or just past the pool
            it.free_offset = OFFSET_W'($urandom_range(0, (1 << (plog - MIN_LOG2)))
                                       << MIN_LOG2);
          end
        end else begin
          it.cmd = CMD_ALLOC;
          k = $urandom_range(0, (plog < 15) ? plog + 1 : 15);
          pick = $urandom_range(0, 99);
          if (pick < 6)       it.req_size = SIZE_W'($urandom);
          else if (pick < 20) it.req_size = SIZE_W'(1 << k);
          else                it.req_size = SIZE_W'($urandom_range(0, 1 << k));
        end
        send_cmd(it, 1'b0, none);
      end
    end

    drain();
    repeat (30) @(negedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
